// ===== src/i2cm_pkg.sv =====
// Shared types and codes for the I2C master register access block.
// Depends on nothing; imported by the sequencer core and the top level.
package i2cm_pkg;

  typedef enum logic [1:0] {
    KIND_TICK     = 2'd0,
    KIND_START_WR = 2'd1,
    KIND_START_RD = 2'd2,
    KIND_SUPPLY   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STAT_NONE  = 2'd0,
    STAT_OK    = 2'd1,
    STAT_ABORT = 2'd2
  } status_e;

  // One input word, unpacked from the stream
  typedef struct packed {
    kind_e      kind;
    logic       sda_in;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] length;
    logic [7:0] write_byte;
  } in_item_t;

  // One result word
  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       busy_res;
    logic       need_byte;
    logic       read_valid;
    logic [7:0] read_byte;
    status_e    status;
  } out_item_t;

endpackage

// ===== src/i2cm_core.sv =====
// Bus sequencer of the I2C master: transaction state and one-word step logic.
// Depends on i2cm_pkg for the input and result word types.
module i2cm_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  i2cm_pkg::in_item_t item_i,
  output i2cm_pkg::out_item_t res_o
);
  import i2cm_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_S1   = 4'd1,
    PH_S2   = 4'd2,
    PH_TX   = 4'd3,
    PH_TACK = 4'd4,
    PH_WAIT = 4'd5,
    PH_RX   = 4'd6,
    PH_RACK = 4'd7,
    PH_STOP = 4'd8
  } phase_e;

  typedef enum logic [1:0] {
    STG_ADDR  = 2'd0,
    STG_REG   = 2'd1,
    STG_RADDR = 2'd2,
    STG_DATA  = 2'd3
  } stage_e;

  phase_e     phase_q, phase_d, ph;
  stage_e     stage_q, stage_d;
  logic       half_q, half_d, hs;
  logic [3:0] bit_q, bit_d, bc, bc_inc;
  logic [7:0] shift_q, shift_d, sh, rx_byte;
  logic [7:0] left_q, left_d, left_dec;
  logic [6:0] taddr_q, taddr_d;
  logic [7:0] raddr_q, raddr_d;
  logic       is_read_q, is_read_d;
  logic       ready_q, ready_d;
  logic       scl_q, scl_d, sda_q, sda_d;
  logic       scl, sda, rvalid;
  logic [7:0] rbyte;
  status_e    status;

  always_comb begin
    phase_d   = phase_q;
    stage_d   = stage_q;
    half_d    = half_q;
    bit_d     = bit_q;
    shift_d   = shift_q;
    left_d    = left_q;
    taddr_d   = taddr_q;
    raddr_d   = raddr_q;
    is_read_d = is_read_q;
    ready_d   = ready_q;
    scl       = scl_q;
    sda       = sda_q;
    rvalid    = 1'b0;
    rbyte     = 8'd0;
    status    = STAT_NONE;
    ph        = phase_q;
    hs        = half_q;
    bc        = bit_q;
    sh        = shift_q;
    bc_inc    = 4'd0;
    rx_byte   = 8'd0;
    left_dec  = left_q - 8'd1;

    case (item_i.kind)
      KIND_START_WR, KIND_START_RD: begin
        if (phase_q == PH_IDLE) begin
          taddr_d   = item_i.dev_addr;
          raddr_d   = item_i.reg_addr;
          left_d    = item_i.length;
          is_read_d = (item_i.kind == KIND_START_RD);
          ready_d   = 1'b0;
          stage_d   = STG_ADDR;
          half_d    = 1'b0;
          bit_d     = 4'd0;
          phase_d   = PH_S1;
        end
      end
      KIND_SUPPLY: begin
        if (phase_q == PH_WAIT && !ready_q) begin
          shift_d = item_i.write_byte;
          ready_d = 1'b1;
        end
      end
      default: begin
        // Pending write byte: launch its transmission on this tick
        if (phase_q == PH_WAIT && ready_q) begin
          ready_d = 1'b0;
          ph      = PH_TX;
          hs      = 1'b0;
          bc      = 4'd0;
        end
        phase_d = ph;
        half_d  = hs;
        bit_d   = bc;
        shift_d = sh;
        bc_inc  = bc + 4'd1;
        case (ph)
          PH_S1: begin
            scl     = 1'b1;
            sda     = 1'b1;
            phase_d = PH_S2;
          end
          PH_S2: begin
            scl     = 1'b1;
            sda     = 1'b0;
            shift_d = {taddr_q, stage_q == STG_RADDR};
            bit_d   = 4'd0;
            half_d  = 1'b0;
            phase_d = PH_TX;
          end
          PH_TX: begin
            sda = sh[7];
            if (!hs) begin
              scl    = 1'b0;
              half_d = 1'b1;
            end else begin
              scl     = 1'b1;
              shift_d = {sh[6:0], 1'b0};
              bit_d   = bc_inc;
              half_d  = 1'b0;
              if (bc_inc[3]) phase_d = PH_TACK;
            end
          end
          PH_TACK: begin
            sda = 1'b1;
            if (!hs) begin
              scl    = 1'b0;
              half_d = 1'b1;
            end else begin
              scl    = 1'b1;
              half_d = 1'b0;
              if (item_i.sda_in) begin
                // Target NACK: drop the transaction without STOP
                status  = STAT_ABORT;
                phase_d = PH_IDLE;
              end else begin
                case (stage_q)
                  STG_ADDR: begin
                    stage_d = STG_REG;
                    shift_d = raddr_q;
                    bit_d   = 4'd0;
                    phase_d = PH_TX;
                  end
                  STG_REG: begin
                    if (is_read_q) begin
                      stage_d = STG_RADDR;
                      phase_d = PH_S1;
                    end else begin
                      stage_d = STG_DATA;
                      phase_d = (left_q == 8'd0) ? PH_STOP : PH_WAIT;
                    end
                  end
                  STG_RADDR: begin
                    stage_d = STG_DATA;
                    shift_d = 8'd0;
                    bit_d   = 4'd0;
                    phase_d = (left_q == 8'd0) ? PH_STOP : PH_RX;
                  end
                  default: begin
                    left_d  = left_dec;
                    phase_d = (left_dec == 8'd0) ? PH_STOP : PH_WAIT;
                  end
                endcase
              end
            end
          end
          PH_WAIT: begin
            scl = 1'b0;
            sda = 1'b1;
          end
          PH_RX: begin
            sda     = 1'b1;
            rx_byte = {sh[6:0], item_i.sda_in};
            if (!hs) begin
              scl    = 1'b0;
              half_d = 1'b1;
            end else begin
              scl     = 1'b1;
              half_d  = 1'b0;
              shift_d = rx_byte;
              bit_d   = bc_inc;
              if (bc_inc[3]) begin
                rvalid  = 1'b1;
                rbyte   = rx_byte;
                phase_d = PH_RACK;
              end
            end
          end
          PH_RACK: begin
            // NACK the last byte, ACK the others
            sda = (left_q <= 8'd1);
            if (!hs) begin
              scl    = 1'b0;
              half_d = 1'b1;
            end else begin
              scl     = 1'b1;
              half_d  = 1'b0;
              left_d  = left_dec;
              shift_d = 8'd0;
              bit_d   = 4'd0;
              phase_d = (left_dec == 8'd0) ? PH_STOP : PH_RX;
            end
          end
          PH_STOP: begin
            scl     = 1'b1;
            sda     = 1'b0;
            status  = STAT_OK;
            phase_d = PH_IDLE;
          end
          default: begin
            scl     = 1'b1;
            sda     = 1'b1;
            phase_d = PH_IDLE;
          end
        endcase
      end
    endcase

    scl_d = scl;
    sda_d = sda;

    res_o.scl        = scl;
    res_o.sda_out    = sda;
    res_o.busy_res   = (phase_d != PH_IDLE);
    res_o.need_byte  = (phase_d == PH_WAIT) && !ready_d;
    res_o.read_valid = rvalid;
    res_o.read_byte  = rbyte;
    res_o.status     = status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      stage_q   <= STG_ADDR;
      half_q    <= 1'b0;
      bit_q     <= 4'd0;
      shift_q   <= 8'd0;
      left_q    <= 8'd0;
      taddr_q   <= 7'd0;
      raddr_q   <= 8'd0;
      is_read_q <= 1'b0;
      ready_q   <= 1'b0;
      scl_q     <= 1'b1;
      sda_q     <= 1'b1;
    end else if (step_i) begin
      phase_q   <= phase_d;
      stage_q   <= stage_d;
      half_q    <= half_d;
      bit_q     <= bit_d;
      shift_q   <= shift_d;
      left_q    <= left_d;
      taddr_q   <= taddr_d;
      raddr_q   <= raddr_d;
      is_read_q <= is_read_d;
      ready_q   <= ready_d;
      scl_q     <= scl_d;
      sda_q     <= sda_d;
    end
  end

endmodule

// ===== src/i2c_master_register_access_core.sv =====
// Top level of the I2C master register access block: stream ports and word registers.
// Depends on i2cm_pkg and i2cm_core.
//
// Usage:
//   Slave channel (s_axis_*): one word per tick or command. tuser carries the
//   kind (tick, start write, start read, supply write byte); tdata carries the
//   sampled SDA level and the command arguments. Each tick stands for one
//   half-period of the bus.
//   Master channel (m_axis_*): exactly one result word per input word, in
//   order, with the SCL/SDA levels to drive, busy and need-byte flags, a
//   received byte with its valid flag, and the transaction status.
//   Result path: an accepted word is held in the input word register; its result
//   is registered in the result register and shown on m_axis_* until taken.
//   Throughput: one word per cycle while m_axis_tready is high; the sequencer step is a single pass of
//   logic between the input word register and the result register.
//   Stall: when the receiver holds tready low, the result register holds; an
//   empty input register still takes one word, and while it is full
//   s_axis_tready stays low until the result is taken.
//   Reset: both word registers empty, the sequencer idle with SCL and SDA
//   released high.
module i2c_master_register_access_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] sda_in, [7:1] dev_addr, [15:8] reg_addr, [23:16] length, [31:24] write_byte
  input  logic [31:0] s_axis_tdata,
  // [1:0] kind
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] scl, [1] sda_out, [2] busy_res, [3] need_byte, [4] read_valid,
  // [12:5] read_byte, [14:13] status, [15] zero
  output logic [15:0] m_axis_tdata
);
  import i2cm_pkg::*;

  logic      in_vld_q;
  in_item_t  in_q;
  in_item_t  in_d;
  logic      out_vld_q;
  out_item_t out_q;
  out_item_t res;
  logic      advance;
  logic      step;

  // Result register frees up when empty or being taken this cycle
  assign advance       = !out_vld_q || m_axis_tready;
  assign step          = in_vld_q && advance;
  assign s_axis_tready = !in_vld_q || advance;

  // Unpack the incoming word
  always_comb begin
    in_d.kind       = kind_e'(s_axis_tuser);
    in_d.sda_in     = s_axis_tdata[0];
    in_d.dev_addr   = s_axis_tdata[7:1];
    in_d.reg_addr   = s_axis_tdata[15:8];
    in_d.length     = s_axis_tdata[23:16];
    in_d.write_byte = s_axis_tdata[31:24];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q <= in_d;
    end
  end

  i2cm_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0, out_q.status, out_q.read_byte, out_q.read_valid,
                          out_q.need_byte, out_q.busy_res, out_q.sda_out, out_q.scl};

endmodule

// ===== src/i2cm_checker.sv =====
// Port-level checks for the I2C master register access block, bound to the top.
// Depends only on the top level's ports.
module i2cm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // A stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // A received byte completes only in the high half of SCL
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[4] |-> m_axis_tdata[0] && m_axis_tdata[2])
    else $error("read byte outside a high SCL half of a busy read");

  // Waiting for a write byte only happens mid-transaction and never with a received byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[2] && !m_axis_tdata[4])
    else $error("need_byte without a busy transaction");

  // Done or abort ends the transaction; done goes with the STOP levels
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[14:13] != 2'd0) |->
      !m_axis_tdata[2] && m_axis_tdata[0] &&
      ((m_axis_tdata[14:13] == 2'd2) || !m_axis_tdata[1]))
    else $error("status reported while still busy or without STOP");

endmodule

bind i2c_master_register_access_core i2cm_checker u_i2cm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
